### src/tdr_pkg.sv
`timescale 1ns / 1ps
package tdr_pkg;

	// widths of the setup values
	localparam int WW = 40;   // edge weights and their steps
	localparam int NW = 64;   // depth numerators and quotients
	localparam int AW = 36;   // absolute area and remainders
	localparam int CB = 11;   // pixel coordinates, up to 2047
	localparam int QDEPTH = 2;
	localparam logic [14:0] CNT_MAX = 15'h7FFF;

	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_PUSH
	} fstate_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DRAW,
		B_DRAIN,
		B_CLEAR,
		B_READ,
		B_RDOUT
	} bstate_t;

	// setup steps run by the shared multiplier
	localparam logic [4:0] ST_AREA_A = 5'd0;
	localparam logic [4:0] ST_AREA_B = 5'd1;
	localparam logic [4:0] ST_W0_A   = 5'd2;
	localparam logic [4:0] ST_W0_B   = 5'd3;
	localparam logic [4:0] ST_W1_A   = 5'd4;
	localparam logic [4:0] ST_W1_B   = 5'd5;
	localparam logic [4:0] ST_W2_A   = 5'd6;
	localparam logic [4:0] ST_W2_B   = 5'd7;
	localparam logic [4:0] ST_N0_A   = 5'd8;
	localparam logic [4:0] ST_N0_B   = 5'd9;
	localparam logic [4:0] ST_N0_C   = 5'd10;
	localparam logic [4:0] ST_NX_A   = 5'd11;
	localparam logic [4:0] ST_NX_B   = 5'd12;
	localparam logic [4:0] ST_NX_C   = 5'd13;
	localparam logic [4:0] ST_NY_A   = 5'd14;
	localparam logic [4:0] ST_NY_B   = 5'd15;
	localparam logic [4:0] ST_NY_C   = 5'd16;

	// divisions run after the products
	localparam logic [1:0] DV_N0 = 2'd0;
	localparam logic [1:0] DV_NX = 2'd1;
	localparam logic [1:0] DV_NY = 2'd2;

	typedef struct packed {
		req_t                   kind;
		logic                   degen;
		logic [CB-1:0]          minx;
		logic [CB-1:0]          maxx;
		logic [CB-1:0]          miny;
		logic [CB-1:0]          maxy;
		logic signed [WW-1:0]   w0;
		logic signed [WW-1:0]   w1;
		logic signed [WW-1:0]   w2;
		logic signed [WW-1:0]   sx0;
		logic signed [WW-1:0]   sx1;
		logic signed [WW-1:0]   sx2;
		logic signed [WW-1:0]   sy0;
		logic signed [WW-1:0]   sy1;
		logic signed [WW-1:0]   sy2;
		logic signed [NW-1:0]   q0;
		logic signed [NW-1:0]   qx;
		logic signed [NW-1:0]   qy;
		logic [AW-1:0]          r0;
		logic [AW-1:0]          rx;
		logic [AW-1:0]          ry;
		logic [AW-1:0]          aabs;
		logic signed [31:0]     fill;
		logic                   rd_ok;
		logic [6:0]             rd_col;
		logic [6:0]             rd_row;
	} setup_t;

endpackage

### src/tdr_front.sv
`timescale 1ns / 1ps
module tdr_front #(
	parameter int FB_WIDTH  = 128,
	parameter int FB_HEIGHT = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            req_type,
	input  logic signed [15:0]    vertex0_x,
	input  logic signed [15:0]    vertex0_y,
	input  logic signed [23:0]    vertex0_depth,
	input  logic signed [15:0]    vertex1_x,
	input  logic signed [15:0]    vertex1_y,
	input  logic signed [23:0]    vertex1_depth,
	input  logic signed [15:0]    vertex2_x,
	input  logic signed [15:0]    vertex2_y,
	input  logic signed [23:0]    vertex2_depth,
	input  logic [6:0]            read_col,
	input  logic [6:0]            read_row,
	output logic                  push,
	output tdr_pkg::setup_t       rec,
	input  logic                  full
);
	import tdr_pkg::*;

	fstate_t st_q, st_d;
	req_t req_q;
	logic signed [15:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
	logic signed [23:0] d0_q, d1_q, d2_q;
	logic [6:0] col_q, row_q;

	logic [4:0] step_q;
	logic [1:0] dig_q;
	logic signed [NW-1:0] acc_q;
	logic signed [NW-1:0] area_q, w0_q, w1_q, w2_q, n0_q, nx_q, ny_q;
	logic degen_q, flip_q;

	logic [NW-1:0] dvd_q;
	logic [AW-1:0] rem_q;
	logic dneg_q;
	logic [5:0] dcnt_q;
	logic [1:0] didx_q;
	logic signed [NW-1:0] q0_q, qx_q, qy_q;
	logic [AW-1:0] r0_q, rx_q, ry_q;

	logic accept;
	assign accept = start && !busy;
	assign busy = (st_q != F_IDLE);

	// bounding box, floor of min and ceiling of max, clamped
	function automatic logic [CB-1:0] clampc(input logic signed [16:0] v, input int lim);
		logic [CB-1:0] r;
		if (v < 0) r = '0;
		else if (32'(v) > lim) r = CB'(lim);
		else r = CB'(v);
		return r;
	endfunction

	function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
		logic signed [15:0] t;
		t = (a < b) ? a : b;
		return (t < c) ? t : c;
	endfunction

	function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
		logic signed [15:0] t;
		t = (a > b) ? a : b;
		return (t > c) ? t : c;
	endfunction

	function automatic logic [NW-2:0] dvd_src_mag(input logic signed [NW-1:0] v);
		logic [NW-1:0] m;
		m = v[NW-1] ? NW'(-v) : NW'(v);
		return m[NW-2:0];
	endfunction

	logic signed [16:0] mnx, mxx, mny, mxy;
	logic [CB-1:0] minx, maxx, miny, maxy;
	assign mnx = 17'(min3(x0_q, x1_q, x2_q)) >>> 4;
	assign mny = 17'(min3(y0_q, y1_q, y2_q)) >>> 4;
	assign mxx = (17'(max3(x0_q, x1_q, x2_q)) + 17'sd15) >>> 4;
	assign mxy = (17'(max3(y0_q, y1_q, y2_q)) + 17'sd15) >>> 4;
	assign minx = clampc(mnx, FB_WIDTH - 1);
	assign maxx = clampc(mxx, FB_WIDTH - 1);
	assign miny = clampc(mny, FB_HEIGHT - 1);
	assign maxy = clampc(mxy, FB_HEIGHT - 1);

	// first pixel centre and edge coefficients
	logic signed [17:0] cx, cy;
	logic signed [17:0] ex0, ey0, ex1, ey1, ex2, ey2;
	assign cx = $signed({3'b000, minx, 4'h8});
	assign cy = $signed({3'b000, miny, 4'h8});
	assign ex0 = 18'(x2_q) - 18'(x1_q);
	assign ey0 = 18'(y2_q) - 18'(y1_q);
	assign ex1 = 18'(x0_q) - 18'(x2_q);
	assign ey1 = 18'(y0_q) - 18'(y2_q);
	assign ex2 = 18'(x1_q) - 18'(x0_q);
	assign ey2 = 18'(y1_q) - 18'(y0_q);

	// winding-corrected weights and per-pixel steps
	logic signed [WW-1:0] wf0, wf1, wf2, sx0, sx1, sx2, sy0, sy1, sy2;
	always_comb begin
		wf0 = flip_q ? -WW'(w0_q) : WW'(w0_q);
		wf1 = flip_q ? -WW'(w1_q) : WW'(w1_q);
		wf2 = flip_q ? -WW'(w2_q) : WW'(w2_q);
		sx0 = flip_q ? (WW'(ey0) <<< 4) : -(WW'(ey0) <<< 4);
		sx1 = flip_q ? (WW'(ey1) <<< 4) : -(WW'(ey1) <<< 4);
		sx2 = flip_q ? (WW'(ey2) <<< 4) : -(WW'(ey2) <<< 4);
		sy0 = flip_q ? -(WW'(ex0) <<< 4) : (WW'(ex0) <<< 4);
		sy1 = flip_q ? -(WW'(ex1) <<< 4) : (WW'(ex1) <<< 4);
		sy2 = flip_q ? -(WW'(ex2) <<< 4) : (WW'(ex2) <<< 4);
	end

	// operand select for the shared digit-serial multiplier
	logic signed [24:0] mul_a;
	logic signed [NW-1:0] mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_AREA_A: begin mul_a = 25'(ex2); mul_b = NW'(18'(y2_q) - 18'(y0_q)); end
			ST_AREA_B: begin mul_a = 25'(ey2); mul_b = NW'(18'(x2_q) - 18'(x0_q)); end
			ST_W0_A:   begin mul_a = 25'(ex0); mul_b = NW'(cy - 18'(y1_q)); end
			ST_W0_B:   begin mul_a = 25'(ey0); mul_b = NW'(cx - 18'(x1_q)); end
			ST_W1_A:   begin mul_a = 25'(ex1); mul_b = NW'(cy - 18'(y2_q)); end
			ST_W1_B:   begin mul_a = 25'(ey1); mul_b = NW'(cx - 18'(x2_q)); end
			ST_W2_A:   begin mul_a = 25'(ex2); mul_b = NW'(cy - 18'(y0_q)); end
			ST_W2_B:   begin mul_a = 25'(ey2); mul_b = NW'(cx - 18'(x0_q)); end
			ST_N0_A:   begin mul_a = 25'(d0_q); mul_b = NW'(wf0); end
			ST_N0_B:   begin mul_a = 25'(d1_q); mul_b = NW'(wf1); end
			ST_N0_C:   begin mul_a = 25'(d2_q); mul_b = NW'(wf2); end
			ST_NX_A:   begin mul_a = 25'(d0_q); mul_b = NW'(sx0); end
			ST_NX_B:   begin mul_a = 25'(d1_q); mul_b = NW'(sx1); end
			ST_NX_C:   begin mul_a = 25'(d2_q); mul_b = NW'(sx2); end
			ST_NY_A:   begin mul_a = 25'(d0_q); mul_b = NW'(sy0); end
			ST_NY_B:   begin mul_a = 25'(d1_q); mul_b = NW'(sy1); end
			ST_NY_C:   begin mul_a = 25'(d2_q); mul_b = NW'(sy2); end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// eight multiplier bits per cycle, sign applied at the end
	logic [24:0] mag;
	logic [7:0] digit;
	logic signed [NW-1:0] part, acc_n, prod, area_n;
	assign mag = mul_a[24] ? 25'(-mul_a) : 25'(mul_a);
	assign digit = 8'(mag >> {dig_q, 3'b000});
	assign part = mul_b * $signed({1'b0, digit});
	assign acc_n = acc_q + (part <<< {dig_q, 3'b000});
	assign prod = mul_a[24] ? -acc_n : acc_n;
	assign area_n = area_q - prod;

	logic mul_done;
	assign mul_done = (st_q == F_MUL) && (dig_q == 2'd2);

	// one quotient bit per cycle
	logic [AW:0] rt;
	logic ge;
	logic [AW-1:0] rem_n;
	logic [NW-1:0] dvd_n;
	logic [AW-1:0] aabs;
	logic signed [NW-1:0] q_fin;
	logic [AW-1:0] r_fin;
	logic signed [NW-1:0] div_src;
	assign aabs = area_q[NW-1] ? AW'(-area_q) : AW'(area_q);
	assign rt = {rem_q, dvd_q[NW-1]};
	assign ge = (rt >= {1'b0, aabs});
	assign rem_n = ge ? AW'(rt - {1'b0, aabs}) : AW'(rt);
	assign dvd_n = {dvd_q[NW-2:0], ge};
	always_comb begin
		if (dneg_q && (rem_n != '0)) begin
			q_fin = -$signed(dvd_n) - 64'sd1;
			r_fin = aabs - rem_n;
		end else if (dneg_q) begin
			q_fin = -$signed(dvd_n);
			r_fin = '0;
		end else begin
			q_fin = $signed(dvd_n);
			r_fin = rem_n;
		end
	end

	logic div_last;
	assign div_last = (st_q == F_DIV) && (dcnt_q == 6'd63);

	always_comb begin
		case (didx_q)
			DV_N0:   div_src = n0_q;
			DV_NX:   div_src = nx_q;
			default: div_src = ny_q;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			F_IDLE: begin
				if (accept) st_d = (req_t'(req_type) == REQ_DRAW) ? F_MUL : F_PUSH;
			end
			F_MUL: begin
				if (mul_done && (step_q == ST_AREA_B) && (area_n == '0)) st_d = F_PUSH;
				else if (mul_done && (step_q == ST_NY_C)) st_d = F_DIV;
			end
			F_DIV: begin
				if (div_last && (didx_q == DV_NY)) st_d = F_PUSH;
			end
			F_PUSH: begin
				if (!full) st_d = F_IDLE;
			end
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= F_IDLE;
		else st_q <= st_d;
	end

	// input latch
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			x0_q <= vertex0_x; y0_q <= vertex0_y; d0_q <= vertex0_depth;
			x1_q <= vertex1_x; y1_q <= vertex1_y; d1_q <= vertex1_depth;
			x2_q <= vertex2_x; y2_q <= vertex2_y; d2_q <= vertex2_depth;
			col_q <= read_col;
			row_q <= read_row;
		end
	end

	// setup sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dig_q <= '0;
			dcnt_q <= '0;
			didx_q <= DV_N0;
			degen_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= ST_AREA_A;
				dig_q <= '0;
				degen_q <= 1'b0;
			end else if (st_q == F_MUL) begin
				if (mul_done) begin
					dig_q <= '0;
					step_q <= step_q + 5'd1;
					if ((step_q == ST_AREA_B) && (area_n == '0)) degen_q <= 1'b1;
				end else begin
					dig_q <= dig_q + 2'd1;
				end
			end
			if (st_q == F_DIV) dcnt_q <= dcnt_q + 6'd1;
			else dcnt_q <= '0;
			if (st_q != F_DIV) didx_q <= DV_N0;
			else if (div_last) didx_q <= didx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_MUL) begin
			acc_q <= mul_done ? '0 : acc_n;
			if (mul_done) begin
				case (step_q)
					ST_AREA_A: area_q <= prod;
					ST_AREA_B: begin area_q <= area_n; flip_q <= area_n[NW-1]; end
					ST_W0_A:   w0_q <= prod;
					ST_W0_B:   w0_q <= w0_q - prod;
					ST_W1_A:   w1_q <= prod;
					ST_W1_B:   w1_q <= w1_q - prod;
					ST_W2_A:   w2_q <= prod;
					ST_W2_B:   w2_q <= w2_q - prod;
					ST_N0_A:   n0_q <= prod;
					ST_N0_B:   n0_q <= n0_q + prod;
					ST_N0_C:   n0_q <= n0_q + prod;
					ST_NX_A:   nx_q <= prod;
					ST_NX_B:   nx_q <= nx_q + prod;
					ST_NX_C:   nx_q <= nx_q + prod;
					ST_NY_A:   ny_q <= prod;
					ST_NY_B:   ny_q <= ny_q + prod;
					ST_NY_C:   ny_q <= ny_q + prod;
					default:   ;
				endcase
			end
		end else begin
			acc_q <= '0;
		end
		// load the next dividend on entry and after each division
		// magnitude sits at the top so 63 steps consume all of it
		if ((st_q == F_DIV) && (dcnt_q == 6'd0)) begin
			dneg_q <= div_src[NW-1];
			dvd_q <= {dvd_src_mag(div_src), 1'b0};
			rem_q <= '0;
		end
		if ((st_q == F_DIV) && (dcnt_q != 6'd0)) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (div_last) begin
			case (didx_q)
				DV_N0:   begin q0_q <= q_fin; r0_q <= r_fin; end
				DV_NX:   begin qx_q <= q_fin; rx_q <= r_fin; end
				default: begin qy_q <= q_fin; ry_q <= r_fin; end
			endcase
		end
	end

	// record handed to the back end
	assign push = (st_q == F_PUSH) && !full;
	always_comb begin
		rec = '0;
		rec.kind   = req_q;
		rec.degen  = degen_q;
		rec.minx   = minx;
		rec.maxx   = maxx;
		rec.miny   = miny;
		rec.maxy   = maxy;
		rec.w0     = wf0;
		rec.w1     = wf1;
		rec.w2     = wf2;
		rec.sx0    = sx0;
		rec.sx1    = sx1;
		rec.sx2    = sx2;
		rec.sy0    = sy0;
		rec.sy1    = sy1;
		rec.sy2    = sy2;
		rec.q0     = q0_q;
		rec.qx     = qx_q;
		rec.qy     = qy_q;
		rec.r0     = r0_q;
		rec.rx     = rx_q;
		rec.ry     = ry_q;
		rec.aabs   = aabs;
		rec.fill   = 32'(d0_q);
		rec.rd_ok  = (32'(col_q) < FB_WIDTH) && (32'(row_q) < FB_HEIGHT);
		rec.rd_col = col_q;
		rec.rd_row = row_q;
	end

endmodule

### src/tdr_queue.sv
`timescale 1ns / 1ps
module tdr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tdr_pkg::setup_t   wdata,
	output logic              full,
	input  logic              pop,
	output tdr_pkg::setup_t   rdata,
	output logic              empty
);
	import tdr_pkg::*;

	setup_t ent_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QDEPTH));
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### src/tdr_back.sv
`timescale 1ns / 1ps
module tdr_back #(
	parameter int FB_WIDTH   = 128,
	parameter int FB_HEIGHT  = 128,
	parameter int DEPTH_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdr_pkg::setup_t               head,
	input  logic                          empty,
	output logic                          pop,
	output logic                          done,
	output logic signed [DEPTH_BITS-1:0]  read_value,
	output logic [14:0]                   pixels_written,
	output logic                          degenerate
);
	import tdr_pkg::*;

	localparam int NPIX = FB_WIDTH * FB_HEIGHT;
	localparam int AB = (NPIX > 1) ? $clog2(NPIX) : 1;
	localparam logic signed [NW-1:0] ZMAX = (64'sd1 <<< (DEPTH_BITS - 1)) - 64'sd1;
	localparam logic signed [NW-1:0] ZMIN = -ZMAX - 64'sd1;

	function automatic logic signed [DEPTH_BITS-1:0] sat(input logic signed [NW-1:0] v);
		logic signed [NW-1:0] t;
		if (v < ZMIN) t = ZMIN;
		else if (v > ZMAX) t = ZMAX;
		else t = v;
		return t[DEPTH_BITS-1:0];
	endfunction

	bstate_t st_q, st_d;
	logic [CB-1:0] px_q, py_q, minx_q, maxx_q, maxy_q;
	logic signed [WW-1:0] w0_q, w1_q, w2_q, wr0_q, wr1_q, wr2_q;
	logic signed [WW-1:0] sx0_q, sx1_q, sx2_q, sy0_q, sy1_q, sy2_q;
	logic signed [NW-1:0] q_q, qrow_q, qx_q, qy_q;
	logic [AW-1:0] r_q, rrow_q, rx_q, ry_q, aabs_q;
	logic signed [DEPTH_BITS-1:0] fill_q;
	logic [AB-1:0] raddr_q, clr_q;
	logic [14:0] cnt_q;

	logic v_s1;
	logic signed [DEPTH_BITS-1:0] z_s1;
	logic [AB-1:0] a_s1;

	logic signed [DEPTH_BITS-1:0] mem [NPIX];
	logic signed [DEPTH_BITS-1:0] rdata_q;

	// pixel address and coverage
	logic [AB-1:0] pix_addr, rd_addr, wr_addr;
	logic covered, row_end, last;
	assign pix_addr = AB'(32'(py_q) * FB_WIDTH + 32'(px_q));
	assign covered = !w0_q[WW-1] && !w1_q[WW-1] && !w2_q[WW-1];
	assign row_end = (px_q == maxx_q);
	assign last = row_end && (py_q == maxy_q);

	// depth steps along the row and down the rows
	logic [AW:0] rsx, rsy;
	logic cgx, cgy;
	logic signed [NW-1:0] q_x, q_y;
	logic [AW-1:0] r_x, r_y;
	assign rsx = {1'b0, r_q} + {1'b0, rx_q};
	assign cgx = (rsx >= {1'b0, aabs_q});
	assign q_x = q_q + qx_q + (cgx ? 64'sd1 : 64'sd0);
	assign r_x = cgx ? AW'(rsx - {1'b0, aabs_q}) : AW'(rsx);
	assign rsy = {1'b0, rrow_q} + {1'b0, ry_q};
	assign cgy = (rsy >= {1'b0, aabs_q});
	assign q_y = qrow_q + qy_q + (cgy ? 64'sd1 : 64'sd0);
	assign r_y = cgy ? AW'(rsy - {1'b0, aabs_q}) : AW'(rsy);

	// depth test and count
	logic upd, we;
	logic [14:0] cnt_d;
	logic signed [DEPTH_BITS-1:0] wr_data;
	assign upd = v_s1 && (z_s1 < rdata_q);
	assign cnt_d = (upd && (cnt_q != CNT_MAX)) ? cnt_q + 15'd1 : cnt_q;
	assign we = upd || (st_q == B_CLEAR);
	assign wr_addr = (st_q == B_CLEAR) ? clr_q : a_s1;
	assign wr_data = (st_q == B_CLEAR) ? fill_q : z_s1;
	assign rd_addr = (st_q == B_DRAW) ? pix_addr : raddr_q;

	// depth store
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	// control and result
	logic fire, f_dg;
	logic signed [DEPTH_BITS-1:0] f_rv;
	logic [14:0] f_pw;
	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		fire = 1'b0;
		f_rv = '0;
		f_pw = '0;
		f_dg = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.kind)
						REQ_DRAW: begin
							if (head.degen) begin
								fire = 1'b1;
								f_dg = 1'b1;
							end else begin
								st_d = B_DRAW;
							end
						end
						REQ_CLEAR: st_d = B_CLEAR;
						REQ_READ: begin
							if (head.rd_ok) st_d = B_READ;
							else fire = 1'b1;
						end
						default: fire = 1'b1;
					endcase
				end
			end
			B_DRAW: begin
				if (last) st_d = B_DRAIN;
			end
			B_DRAIN: begin
				fire = 1'b1;
				f_pw = cnt_d;
				st_d = B_IDLE;
			end
			B_CLEAR: begin
				if (32'(clr_q) == NPIX - 1) begin
					fire = 1'b1;
					st_d = B_IDLE;
				end
			end
			B_READ: st_d = B_RDOUT;
			B_RDOUT: begin
				fire = 1'b1;
				f_rv = rdata_q;
				st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			v_s1 <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			v_s1 <= (st_q == B_DRAW) && covered;
			done <= fire;
			if (pop) cnt_q <= '0;
			else cnt_q <= cnt_d;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (fire) begin
			read_value <= f_rv;
			pixels_written <= f_pw;
			degenerate <= f_dg;
		end
	end

	// walker datapath
	always_ff @(posedge clk) begin
		z_s1 <= sat(q_q);
		a_s1 <= pix_addr;
		if (pop) begin
			px_q <= head.minx;
			py_q <= head.miny;
			minx_q <= head.minx;
			maxx_q <= head.maxx;
			maxy_q <= head.maxy;
			w0_q <= head.w0; w1_q <= head.w1; w2_q <= head.w2;
			wr0_q <= head.w0; wr1_q <= head.w1; wr2_q <= head.w2;
			sx0_q <= head.sx0; sx1_q <= head.sx1; sx2_q <= head.sx2;
			sy0_q <= head.sy0; sy1_q <= head.sy1; sy2_q <= head.sy2;
			q_q <= head.q0; qrow_q <= head.q0;
			r_q <= head.r0; rrow_q <= head.r0;
			qx_q <= head.qx; qy_q <= head.qy;
			rx_q <= head.rx; ry_q <= head.ry;
			aabs_q <= head.aabs;
			fill_q <= sat(64'(head.fill));
			raddr_q <= AB'(32'(head.rd_row) * FB_WIDTH + 32'(head.rd_col));
			clr_q <= '0;
		end else if (st_q == B_DRAW) begin
			if (!row_end) begin
				px_q <= px_q + CB'(1);
				w0_q <= w0_q + sx0_q;
				w1_q <= w1_q + sx1_q;
				w2_q <= w2_q + sx2_q;
				q_q <= q_x;
				r_q <= r_x;
			end else if (!last) begin
				px_q <= minx_q;
				py_q <= py_q + CB'(1);
				w0_q <= wr0_q + sy0_q; wr0_q <= wr0_q + sy0_q;
				w1_q <= wr1_q + sy1_q; wr1_q <= wr1_q + sy1_q;
				w2_q <= wr2_q + sy2_q; wr2_q <= wr2_q + sy2_q;
				q_q <= q_y; qrow_q <= q_y;
				r_q <= r_y; rrow_q <= r_y;
			end
		end else if (st_q == B_CLEAR) begin
			clr_q <= clr_q + AB'(1);
		end
	end

	// checks
	a_s1_src: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(st_q == B_DRAW))
		else $error("depth test with no pixel issued");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_DRAIN |=> st_q == B_IDLE && done)
		else $error("draw did not finish after drain");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> pixels_written == 15'd0 && read_value == '0)
		else $error("degenerate result carries data");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> st_q == B_CLEAR || st_q == B_DRAW || st_q == B_DRAIN)
		else $error("store written outside clear or draw");

endmodule

### src/triangle_depth_rasterizer.sv
`timescale 1ns / 1ps
// channel   dir   handshake            payload
// request   in    start && !busy       req_type, vertex0..2 x/y/depth, read_col, read_row
// result    out   done, one cycle      read_value, pixels_written, degenerate
//
// Draw setup runs on one digit-serial multiplier and a one-bit-per-cycle divider; the
// walk then covers one box pixel per cycle. A clear writes FB_WIDTH*FB_HEIGHT entries,
// one per cycle; a read returns the registered store output.
// Setup of the next request overlaps the current walk through a two-entry queue.
// Reset leaves the depth store unwritten; the receiver cannot stall results.
module triangle_depth_rasterizer #(
	parameter int FB_WIDTH   = 128,
	parameter int FB_HEIGHT  = 128,
	parameter int DEPTH_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic signed [15:0]            vertex0_x,
	input  logic signed [15:0]            vertex0_y,
	input  logic signed [23:0]            vertex0_depth,
	input  logic signed [15:0]            vertex1_x,
	input  logic signed [15:0]            vertex1_y,
	input  logic signed [23:0]            vertex1_depth,
	input  logic signed [15:0]            vertex2_x,
	input  logic signed [15:0]            vertex2_y,
	input  logic signed [23:0]            vertex2_depth,
	input  logic [6:0]                    read_col,
	input  logic [6:0]                    read_row,
	output logic                          done,
	output logic signed [DEPTH_BITS-1:0]  read_value,
	output logic [14:0]                   pixels_written,
	output logic                          degenerate
);
	import tdr_pkg::*;

	setup_t wrec, hrec;
	logic push, full, pop, empty;

	// request setup
	tdr_front #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type),
		.vertex0_x(vertex0_x), .vertex0_y(vertex0_y), .vertex0_depth(vertex0_depth),
		.vertex1_x(vertex1_x), .vertex1_y(vertex1_y), .vertex1_depth(vertex1_depth),
		.vertex2_x(vertex2_x), .vertex2_y(vertex2_y), .vertex2_depth(vertex2_depth),
		.read_col(read_col), .read_row(read_row),
		.push(push), .rec(wrec), .full(full)
	);

	// setup queue
	tdr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wrec), .full(full),
		.pop(pop), .rdata(hrec), .empty(empty)
	);

	// walker and depth store
	tdr_back #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT), .DEPTH_BITS(DEPTH_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(hrec), .empty(empty), .pop(pop),
		.done(done), .read_value(read_value), .pixels_written(pixels_written),
		.degenerate(degenerate)
	);

endmodule
